// ===== rtl/core/skm_pkg.sv =====
`default_nettype none
package skm_pkg;

    localparam int POS_W  = 10;
    localparam int BITS_W = 32;
    localparam int MINC_W = 14;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_BEGIN    = 2'd1;
    localparam logic [1:0] CMD_KMER     = 2'd2;
    localparam logic [1:0] CMD_CLASSIFY = 2'd3;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_MATCH    = 3'd1;
    localparam logic [2:0] STS_NOMATCH  = 3'd2;
    localparam logic [2:0] STS_BELOW    = 3'd3;
    localparam logic [2:0] STS_CLOSED   = 3'd4;
    localparam logic [2:0] STS_ORDER    = 3'd5;
    localparam logic [2:0] STS_FULL     = 3'd6;
    localparam logic [2:0] STS_UNSORTED = 3'd7;

    localparam logic [MINC_W-1:0] MIN_COUNT_RESET = 14'd5;
    localparam logic [2:0]        ADDR_MIN_COUNT  = 3'd0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [61:0] kmer;
        logic [31:0] count;
    } skm_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  pattern_index;
        logic              pattern_new;
        logic [BITS_W-1:0] pattern_bits;
    } skm_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CLS_READ,
        ST_CLS_WALK
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/skm_target_mem.sv =====
`default_nettype none
module skm_target_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int KW    = 62,
    parameter int NS    = 32
) (
    input  wire logic          clk,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic          t_we,
    input  wire logic [AW-1:0] t_waddr,
    input  wire logic [KW-1:0] t_wdata,
    input  wire logic          p_we,
    input  wire logic [AW-1:0] p_waddr,
    input  wire logic [NS-1:0] p_wdata,
    output logic      [KW-1:0] t_rdata,
    output logic      [NS-1:0] p_rdata
);

    logic [KW-1:0] target_mem [DEPTH];
    logic [NS-1:0] presence_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            target_mem[t_waddr] <= t_wdata;
        end
        t_rdata <= target_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            presence_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= presence_mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/skm_pattern_table.sv =====
`default_nettype none
module skm_pattern_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int TW    = 11,
    parameter int NS    = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NS-1:0] pattern,
    output logic               done,
    output logic      [TW-1:0] index,
    output logic               is_new
);

    logic [NS-1:0] uniq_mem [DEPTH];
    logic [NS-1:0] rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          we;

    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] u_reg, u_next;
    logic [NS-1:0] pat_reg, pat_next;
    logic          walking_reg, walking_next;
    logic          done_reg, done_next;
    logic [TW-1:0] index_reg, index_next;
    logic          new_reg, new_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            uniq_mem[total_reg[AW-1:0]] <= pat_reg;
        end
        rdata_reg <= uniq_mem[rd_addr];
    end

    assign rd_addr = walking_reg ? AW'(u_reg + 1'b1) : '0;

    always_comb
    begin
        total_next   = total_reg;
        u_next       = u_reg;
        pat_next     = pat_reg;
        walking_next = walking_reg;
        done_next    = 1'b0;
        index_next   = index_reg;
        new_next     = new_reg;
        we           = 1'b0;
        if (start)
        begin
            pat_next     = pattern;
            u_next       = '0;
            walking_next = 1'b1;
        end
        else if (walking_reg)
        begin
            if (total_reg != '0 && rdata_reg == pat_reg)
            begin
                walking_next = 1'b0;
                done_next    = 1'b1;
                index_next   = u_reg;
                new_next     = 1'b0;
            end
            else if (total_reg != '0 && (u_reg + 1'b1) < total_reg)
            begin
                u_next = u_reg + 1'b1;
            end
            else
            begin
                // Pattern not in the table: it takes the next dense index.
                walking_next = 1'b0;
                done_next    = 1'b1;
                index_next   = total_reg;
                new_next     = 1'b1;
                if (total_reg < TW'(DEPTH))
                begin
                    we         = 1'b1;
                    total_next = total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            walking_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            walking_reg <= walking_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        pat_reg   <= pat_next;
        index_reg <= index_next;
        new_reg   <= new_next;
    end

    assign done   = done_reg;
    assign index  = index_reg;
    assign is_new = new_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_kmer_presence_matcher_core.sv =====
// Channel   Signals                        Transaction
// input     start, busy, item              start high while busy low
// result    done, result                   done high for one cycle
// config    psel..pready, paddr, pwdata    psel, penable, pwrite high
//
// A load, a sample begin and any command answered from flags finish in idle,
// with the result registered in the cycle after. A sample kmer that searches walks
// the targets in order from the search pointer, comparing them on the single read
// port of the target memory. A classify reads a presence word, then walks the
// stored patterns in the pattern table. Reset clears all counters and flags; no
// clearing pass is needed. The result cannot be stalled; busy holds off new items.
`default_nettype none
module sorted_kmer_presence_matcher_core
    import skm_pkg::*;
#(
    parameter int NUM_TARGETS = 1024,
    parameter int NUM_SAMPLES = 32,
    parameter int KMER_LEN    = 31
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire skm_item_t   item,
    output logic             done,
    output skm_result_t      result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW  = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int TW  = $clog2(NUM_TARGETS + 1);
    localparam int KW  = 2 * KMER_LEN;
    localparam int NS  = NUM_SAMPLES;
    localparam int SNW = $clog2(NUM_SAMPLES + 1);

    state_t state_reg, state_next;

    logic [MINC_W-1:0] min_count_reg;
    logic [TW-1:0]     total_reg, total_next;
    logic [TW-1:0]     sp_reg, sp_next;
    logic [TW-1:0]     cp_reg, cp_next;
    logic [TW-1:0]     idx_reg, idx_next;
    logic [SNW-1:0]    sample_reg, sample_next;
    logic [KW-1:0]     prev_reg, prev_next;
    logic [KW-1:0]     first_reg, first_next;
    logic [KW-1:0]     last_reg, last_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [NS-1:0]     pat_reg, pat_next;
    logic              seen_reg, seen_next;
    logic              closed_reg, closed_next;
    logic              error_reg, error_next;
    logic              unsorted_reg, unsorted_next;
    logic              done_reg, done_next;
    skm_result_t       res_reg, res_next;

    logic          accept;
    logic [KW-1:0] k_in;
    logic [AW-1:0] rd_addr;
    logic          t_we;
    logic          p_we;
    logic [AW-1:0] p_waddr;
    logic [NS-1:0] p_wdata;
    logic [KW-1:0] t_rdata;
    logic [NS-1:0] p_rdata;
    logic          pt_start;
    logic          pt_done;
    logic [TW-1:0] pt_index;
    logic          pt_new;

    assign accept = start && !busy;
    assign k_in   = item.kmer[KW-1:0];
    assign busy   = (state_reg != ST_IDLE);

    assign rd_addr = (state_reg == ST_SEARCH) ? AW'(idx_reg + 1'b1)
                   : (item.cmd == CMD_CLASSIFY) ? AW'(cp_reg) : AW'(sp_reg);

    skm_target_mem #(
        .DEPTH(NUM_TARGETS),
        .AW(AW),
        .KW(KW),
        .NS(NS)
    ) u_target_mem (
        .clk(clk),
        .rd_addr(rd_addr),
        .t_we(t_we),
        .t_waddr(AW'(total_reg)),
        .t_wdata(k_in),
        .p_we(p_we),
        .p_waddr(p_waddr),
        .p_wdata(p_wdata),
        .t_rdata(t_rdata),
        .p_rdata(p_rdata)
    );

    skm_pattern_table #(
        .DEPTH(NUM_TARGETS),
        .AW(AW),
        .TW(TW),
        .NS(NS)
    ) u_pattern_table (
        .clk(clk),
        .rst_n(rst_n),
        .start(pt_start),
        .pattern(p_rdata),
        .done(pt_done),
        .index(pt_index),
        .is_new(pt_new)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.cmd == CMD_KMER && !unsorted_reg && sample_reg != '0
                    && !closed_reg && !error_reg && !(seen_reg && k_in <= prev_reg)
                    && {18'd0, min_count_reg} <= item.count && total_reg != '0
                    && k_in <= last_reg && k_in >= first_reg && sp_reg < total_reg)
                begin
                    state_next = ST_SEARCH;
                end
                else if (accept && item.cmd == CMD_CLASSIFY && !unsorted_reg
                         && cp_reg < total_reg)
                begin
                    state_next = ST_CLS_READ;
                end
            end
            ST_SEARCH:
            begin
                if (t_rdata == key_reg || (idx_reg + 1'b1) >= total_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLS_READ:
            begin
                state_next = ST_CLS_WALK;
            end
            ST_CLS_WALK:
            begin
                if (pt_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        total_next    = total_reg;
        sp_next       = sp_reg;
        cp_next       = cp_reg;
        idx_next      = idx_reg;
        sample_next   = sample_reg;
        prev_next     = prev_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        key_next      = key_reg;
        pat_next      = pat_reg;
        seen_next     = seen_reg;
        closed_next   = closed_reg;
        error_next    = error_reg;
        unsorted_next = unsorted_reg;
        done_next     = 1'b0;
        res_next      = '0;
        t_we          = 1'b0;
        p_we          = 1'b0;
        p_waddr       = AW'(total_reg);
        p_wdata       = '0;
        pt_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (item.cmd)
                        CMD_LOAD:
                        begin
                            if (total_reg >= TW'(NUM_TARGETS))
                            begin
                                res_next.status = STS_FULL;
                            end
                            else
                            begin
                                t_we       = 1'b1;
                                p_we       = 1'b1;
                                last_next  = k_in;
                                total_next = total_reg + 1'b1;
                                if (total_reg == '0)
                                begin
                                    first_next = k_in;
                                end
                                if (unsorted_reg || (total_reg != '0 && k_in < last_reg))
                                begin
                                    unsorted_next   = 1'b1;
                                    res_next.status = STS_UNSORTED;
                                end
                                else
                                begin
                                    res_next.status = STS_OK;
                                end
                            end
                        end
                        CMD_BEGIN:
                        begin
                            if (sample_reg >= SNW'(NUM_SAMPLES))
                            begin
                                res_next.status = STS_FULL;
                            end
                            else
                            begin
                                sample_next     = sample_reg + 1'b1;
                                sp_next         = '0;
                                prev_next       = '0;
                                seen_next       = 1'b0;
                                closed_next     = 1'b0;
                                error_next      = 1'b0;
                                res_next.status = STS_OK;
                            end
                        end
                        CMD_KMER:
                        begin
                            if (unsorted_reg)
                            begin
                                res_next.status = STS_UNSORTED;
                            end
                            else if (sample_reg == '0 || closed_reg)
                            begin
                                res_next.status = STS_CLOSED;
                            end
                            else if (error_reg)
                            begin
                                res_next.status = STS_ORDER;
                            end
                            else if (seen_reg && k_in <= prev_reg)
                            begin
                                error_next      = 1'b1;
                                res_next.status = STS_ORDER;
                            end
                            else
                            begin
                                prev_next = k_in;
                                seen_next = 1'b1;
                                if ({18'd0, min_count_reg} > item.count)
                                begin
                                    res_next.status = STS_BELOW;
                                end
                                else if (total_reg == '0 || k_in > last_reg)
                                begin
                                    closed_next     = 1'b1;
                                    res_next.status = STS_CLOSED;
                                end
                                else if (k_in < first_reg || sp_reg >= total_reg)
                                begin
                                    res_next.status = STS_NOMATCH;
                                end
                                else
                                begin
                                    // The walk starts at the search pointer; read is in flight.
                                    done_next = 1'b0;
                                    idx_next  = sp_reg;
                                    key_next  = k_in;
                                end
                            end
                        end
                        CMD_CLASSIFY:
                        begin
                            if (unsorted_reg)
                            begin
                                res_next.status = STS_UNSORTED;
                            end
                            else if (cp_reg >= total_reg)
                            begin
                                res_next.status = STS_CLOSED;
                            end
                            else
                            begin
                                done_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_next.status = STS_OK;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (t_rdata == key_reg)
                begin
                    p_we              = 1'b1;
                    p_waddr           = AW'(idx_reg);
                    p_wdata           = p_rdata | (NS'(1) << (sample_reg - 1'b1));
                    sp_next           = idx_reg + 1'b1;
                    done_next         = 1'b1;
                    res_next.status   = STS_MATCH;
                    res_next.position = POS_W'(idx_reg);
                end
                else if ((idx_reg + 1'b1) < total_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    done_next       = 1'b1;
                    res_next.status = STS_NOMATCH;
                end
            end
            ST_CLS_READ:
            begin
                pt_start = 1'b1;
                pat_next = p_rdata;
            end
            ST_CLS_WALK:
            begin
                if (pt_done)
                begin
                    done_next              = 1'b1;
                    res_next.status        = STS_OK;
                    res_next.position      = POS_W'(cp_reg);
                    res_next.pattern_index = POS_W'(pt_index);
                    res_next.pattern_new   = pt_new;
                    res_next.pattern_bits  = BITS_W'(pat_reg);
                    cp_next                = cp_reg + 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            sp_reg        <= '0;
            cp_reg        <= '0;
            sample_reg    <= '0;
            prev_reg      <= '0;
            seen_reg      <= 1'b0;
            closed_reg    <= 1'b0;
            error_reg     <= 1'b0;
            unsorted_reg  <= 1'b0;
            done_reg      <= 1'b0;
            min_count_reg <= MIN_COUNT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            sp_reg       <= sp_next;
            cp_reg       <= cp_next;
            sample_reg   <= sample_next;
            prev_reg     <= prev_next;
            seen_reg     <= seen_next;
            closed_reg   <= closed_next;
            error_reg    <= error_next;
            unsorted_reg <= unsorted_next;
            done_reg     <= done_next;
            if (psel && penable && pwrite && paddr == ADDR_MIN_COUNT)
            begin
                min_count_reg <= pwdata[MINC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        key_reg   <= key_next;
        pat_reg   <= pat_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_COUNT) ? {18'd0, min_count_reg} : 32'd0;

endmodule
`default_nettype wire
